/* hw/rtl/b64d_pkg.sv */
// Shared types, constants and the alphabet lookup for the base64 stream decoder.
package b64d_pkg;

    // Default depth of the queue between front and back (power of two, at least 2).
    localparam int QUEUE_DEPTH_DEF = 4;

    // One burst of results produced by one accepted character.
    typedef struct packed {
        logic [23:0] bytes;     // first byte in [23:16]
        logic [1:0]  nres;      // number of results, 1..3 (0 = nothing to send)
        logic        has_byte;  // 0 only for the end-only marker
        logic        done;      // last result of the burst closes the string
    } b64d_desc_t;

    localparam int DESC_W = $bits(b64d_desc_t);

    // Status of the queue, seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } b64d_qstat_t;

    // Alphabet lookup: bit 6 = in alphabet, bits 5:0 = sextet value.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        case (c) inside
            [8'h41:8'h5A]: r = {1'b1, 6'(c - 8'h41)};
            [8'h61:8'h7A]: r = {1'b1, 6'(c - 8'h61 + 8'd26)};
            [8'h30:8'h39]: r = {1'b1, 6'(c - 8'h30 + 8'd52)};
            8'h2B:         r = {1'b1, 6'd62};
            8'h2F:         r = {1'b1, 6'd63};
            default:       r = 7'd0;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/b64d_front.sv */
// Front end: accepts characters, tracks the sextet group, builds result bursts.
module b64d_front
    import b64d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_ready,
    input  logic [7:0]  char_code,
    input  logic        end_of_text,
    input  b64d_qstat_t qstat,
    output logic        push,
    output b64d_desc_t  push_desc
);

    logic [17:0] buf_reg, buf_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        stopped_reg, stopped_next;

    logic [6:0]  sx;
    logic [17:0] buf_mid;
    logic [1:0]  cnt_mid;
    logic        stop_mid;
    logic [23:0] char_bytes, end_bytes;
    logic [1:0]  char_n, end_n;
    logic        accept;

    // Partial-group flush: (count - 1) bytes, left aligned.
    function automatic logic [25:0] flush(input logic [17:0] b, input logic [1:0] c);
        logic [25:0] r;
        r = 26'd0;
        case (c)
            2'd2:    r = {2'd1, b[11:0], 12'h000};
            2'd3:    r = {2'd2, b[17:0], 6'h00};
            default: r = 26'd0;
        endcase
        return r;
    endfunction

    assign char_ready = !qstat.full;
    assign accept     = char_valid && char_ready;
    assign sx         = sextet_of(char_code);

    always_comb
    begin
        buf_mid    = buf_reg;
        cnt_mid    = cnt_reg;
        stop_mid   = stopped_reg;
        char_bytes = 24'h0;
        char_n     = 2'd0;
        end_bytes  = 24'h0;
        end_n      = 2'd0;

        if (!stopped_reg)
        begin
            if (!sx[6])
            begin
                {char_n, char_bytes} = flush(buf_reg, cnt_reg);
                buf_mid  = 18'h0;
                cnt_mid  = 2'd0;
                stop_mid = 1'b1;
            end
            else if (cnt_reg == 2'd3)
            begin
                char_bytes = {buf_reg, sx[5:0]};
                char_n     = 2'd3;
                buf_mid    = 18'h0;
                cnt_mid    = 2'd0;
            end
            else
            begin
                buf_mid = {buf_reg[11:0], sx[5:0]};
                cnt_mid = cnt_reg + 2'd1;
            end
        end

        if (end_of_text && !stop_mid)
            {end_n, end_bytes} = flush(buf_mid, cnt_mid);

        // At most one of the two sources yields bytes.
        push_desc.bytes    = (char_n != 2'd0) ? char_bytes : end_bytes;
        push_desc.nres     = char_n | end_n;
        push_desc.has_byte = 1'b1;
        push_desc.done     = end_of_text;
        if (end_of_text && push_desc.nres == 2'd0)
        begin
            push_desc.bytes    = 24'h0;
            push_desc.nres     = 2'd1;
            push_desc.has_byte = 1'b0;
        end

        push = accept && (push_desc.nres != 2'd0);

        buf_next     = buf_reg;
        cnt_next     = cnt_reg;
        stopped_next = stopped_reg;
        if (accept)
        begin
            if (end_of_text)
            begin
                buf_next     = 18'h0;
                cnt_next     = 2'd0;
                stopped_next = 1'b0;
            end
            else
            begin
                buf_next     = buf_mid;
                cnt_next     = cnt_mid;
                stopped_next = stop_mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg     <= 18'h0;
            cnt_reg     <= 2'd0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            buf_reg     <= buf_next;
            cnt_reg     <= cnt_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

/* hw/rtl/b64d_queue.sv */
// Small register queue carrying result bursts from the front to the back.
module b64d_queue
    import b64d_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int WIDTH = DESC_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output b64d_qstat_t      qstat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign head_data   = slot_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == CW'(DEPTH));
    assign qstat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hw/rtl/b64d_back.sv */
// Back end: unpacks bursts into one result per cycle, while byte_ready is high, into the output register.
module b64d_back
    import b64d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  b64d_qstat_t qstat,
    input  b64d_desc_t  head_desc,
    output logic        pop,
    output logic        byte_valid,
    input  logic        byte_ready,
    output logic [7:0]  data_byte,
    output logic        has_byte,
    output logic        run_last,
    output logic        text_done
);

    b64d_desc_t  desc_reg, desc_next;
    logic        desc_valid_reg, desc_valid_next;
    logic [1:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  data_reg, data_next;
    logic        has_reg, has_next;
    logic        last_reg, last_next;
    logic        done_reg, done_next;

    logic        load;
    logic        is_last;
    logic [7:0]  cur_byte;

    assign byte_valid = out_valid_reg;
    assign data_byte  = data_reg;
    assign has_byte   = has_reg;
    assign run_last   = last_reg;
    assign text_done  = done_reg;

    always_comb
    begin
        load    = !out_valid_reg || byte_ready;
        is_last = (idx_reg == desc_reg.nres - 2'd1);
        case (idx_reg)
            2'd0:    cur_byte = desc_reg.bytes[23:16];
            2'd1:    cur_byte = desc_reg.bytes[15:8];
            default: cur_byte = desc_reg.bytes[7:0];
        endcase

        out_valid_next  = out_valid_reg && !byte_ready;
        data_next       = data_reg;
        has_next        = has_reg;
        last_next       = last_reg;
        done_next       = done_reg;
        desc_next       = desc_reg;
        desc_valid_next = desc_valid_reg;
        idx_next        = idx_reg;

        if (load && desc_valid_reg)
        begin
            out_valid_next = 1'b1;
            data_next      = cur_byte;
            has_next       = desc_reg.has_byte;
            last_next      = is_last;
            done_next      = is_last && desc_reg.done;
            idx_next       = idx_reg + 2'd1;
            if (is_last)
                desc_valid_next = 1'b0;
        end

        // Refill the burst register as soon as the current one is used up.
        pop = !qstat.empty && (!desc_valid_reg || (load && is_last));
        if (pop)
        begin
            desc_next       = head_desc;
            desc_valid_next = 1'b1;
            idx_next        = 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
        data_reg <= data_next;
        has_reg  <= has_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_valid_reg <= 1'b0;
            idx_reg        <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            desc_valid_reg <= desc_valid_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

/* hw/rtl/base64_stream_decoder_top.sv */
// Top level of the streaming base64 decoder: front end, burst queue, back end.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+------------------------------
//  char    | char_valid, char_ready, char_code,        | one encoded character per
//          | end_of_text                               | transaction, end mark on last
//  byte    | byte_valid, byte_ready, data_byte,        | one decoded byte or end-only
//          | has_byte, run_last, text_done             | marker per transaction
//
//  - A character is taken every cycle while the burst queue has room; each character
//    yields 0 to 3 results, written into the queue as one burst in the same cycle.
//  - While byte_ready is high the back end sends one result per cycle, so sustained input
//    is one character a cycle for plain text (3 bytes per 4 characters); a run of bursts
//    of three is bounded by the single output port at one result a cycle.
//  - An accepted character's results pass through the queue, the burst register and then the output register.
//  - Reset (rst_n low, asynchronous) empties the queue, clears the valid flag of the output
//    register and returns the decoder to an empty group with decoding active.
//  - A stall on the byte side fills the queue (QUEUE_DEPTH bursts) and then drops
//    char_ready; the output register keeps its transaction until it is taken.
module base64_stream_decoder_top
    import b64d_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_ready,
    input  logic [7:0] char_code,
    input  logic       end_of_text,
    output logic       byte_valid,
    input  logic       byte_ready,
    output logic [7:0] data_byte,
    output logic       has_byte,
    output logic       run_last,
    output logic       text_done
);

    b64d_qstat_t qstat;
    b64d_desc_t  push_desc;
    b64d_desc_t  head_desc;
    logic        push;
    logic        pop;

    // Front: alphabet lookup, group tracking, stop and flush handling.
    b64d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_code  (char_code),
        .end_of_text(end_of_text),
        .qstat      (qstat),
        .push       (push),
        .push_desc  (push_desc)
    );

    // Queue of bursts lets the front keep accepting while the back drains.
    b64d_queue #(
        .DEPTH(QUEUE_DEPTH),
        .WIDTH(DESC_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_desc),
        .pop       (pop),
        .head_data (head_desc),
        .qstat     (qstat)
    );

    // Back: one result per cycle into the output register while byte_ready is high.
    b64d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .head_desc (head_desc),
        .pop       (pop),
        .byte_valid(byte_valid),
        .byte_ready(byte_ready),
        .data_byte (data_byte),
        .has_byte  (has_byte),
        .run_last  (run_last),
        .text_done (text_done)
    );

    // The front never writes a burst into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("burst written into full queue");

    // The back never reads an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("burst read from empty queue");

    // The end of the string is always the last result of its character.
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && text_done |-> run_last)
        else $error("text_done without run_last");

    // An end-only marker closes the string and carries a zero byte.
    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !has_byte |-> text_done && run_last && (data_byte == 8'h00))
        else $error("malformed end-only marker");

endmodule
